@@ rtl/core/tzpf_pkg.sv @@
// ----------------------------------------------------------------------------
// tzpf_pkg
// Shared widths, status codes and register indexes for the zone presence
// fusion block.
// ----------------------------------------------------------------------------
package tzpf_pkg;

  localparam int unsigned IdxW    = 6;   // zone index
  localparam int unsigned DistW   = 16;  // signed distance
  localparam int unsigned MagW    = 15;  // positive distance magnitude
  localparam int unsigned StatW   = 8;
  localparam int unsigned MotW    = 5;
  localparam int unsigned NearW   = 7;
  localparam int unsigned TotW    = 17;  // centre sum
  localparam int unsigned HitW    = 3;
  localparam int unsigned CntW    = 8;   // streak and latch
  localparam int unsigned MapW    = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  localparam logic [StatW-1:0] StatusValidA = 8'd5;
  localparam logic [StatW-1:0] StatusValidB = 8'd9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NEAR_DIST   = 3'd0,
    REG_MIN_NEAR    = 3'd1,
    REG_DEBOUNCE    = 3'd2,
    REG_MOTION_MIN  = 3'd3,
    REG_LATCH_RELD  = 3'd4,
    REG_CENTER_MAP  = 3'd5
  } cfg_reg_e;

endpackage

@@ rtl/core/tof_zone_presence_fusion.sv @@
// ----------------------------------------------------------------------------
// tof_zone_presence_fusion
// Per-frame presence and motion fusion over a stream of ranging zones.
// ----------------------------------------------------------------------------
// Each zone word is captured and then walks the centre slots in turn, since
// a single index comparator and accumulator serve all the slots (the near
// test rides along with the first slot). The last zone of a frame adds the
// close-out: a bit-serial restoring divider for the centre mean (skipped
// when no centre zone hit) and a final state that updates debounce, motion
// latch and fusion and loads the result register. That final state waits
// while a previous result word is still stalled at the output.
// Zone input is stalled throughout the per-word work.
module tof_zone_presence_fusion #(
  parameter int unsigned ZONES        = 64,
  parameter int unsigned CENTER_COUNT = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tzpf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tzpf_pkg::CfgDatW-1:0]  cfg_data_i,
  // zone input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tzpf_pkg::IdxW-1:0]     zone_index_i,
  input  logic signed [tzpf_pkg::DistW-1:0] zone_distance_i,
  input  logic [tzpf_pkg::StatW-1:0]    zone_status_i,
  input  logic                          last_zone_i,
  input  logic [tzpf_pkg::MotW-1:0]     motion_count_i,
  // frame result
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          fused_present_o,
  output logic                          presence_confirmed_o,
  output logic                          presence_flipped_o,
  output logic                          fused_flipped_o,
  output logic [tzpf_pkg::NearW-1:0]    near_zones_o,
  output logic                          center_ok_o,
  output logic [tzpf_pkg::MagW-1:0]     center_mean_mm_o,
  output logic [tzpf_pkg::MotW-1:0]     motion_count_echo_o,
  output logic [tzpf_pkg::CntW-1:0]     latch_level_o
);
  import tzpf_pkg::*;

  localparam int unsigned SlotW   = (CENTER_COUNT > 1) ? $clog2(CENTER_COUNT) : 1;
  localparam int unsigned DivCtrW = $clog2(TotW);

  localparam logic [SlotW-1:0]   LastSlot  = SlotW'(CENTER_COUNT - 1);
  localparam logic [NearW-1:0]   ZonesLim  = NearW'(ZONES);
  localparam logic [HitW-1:0]    HitsLim   = HitW'(CENTER_COUNT);
  localparam logic [DivCtrW-1:0] DivLast   = DivCtrW'(TotW - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLOT,
    S_DIV,
    S_FIN
  } state_e;

  state_e state_q;

  // configuration registers
  logic [MagW-1:0]  near_dist_q;
  logic [NearW-1:0] min_near_q;
  logic [CntW-1:0]  debounce_q;
  logic [MotW-1:0]  motion_min_q;
  logic [CntW-1:0]  latch_reload_q;
  logic [MapW-1:0]  center_map_q;

  // captured zone word
  logic [IdxW-1:0]  zone_idx_q;
  logic [MagW-1:0]  dist_q;
  logic             usable_q;
  logic             last_q;
  logic [MotW-1:0]  mcount_q;

  // frame and persistent state
  logic [NearW-1:0] near_tally_q;
  logic [TotW-1:0]  center_total_q;
  logic [HitW-1:0]  center_hits_q;
  logic             presence_q;
  logic [CntW-1:0]  flip_streak_q;
  logic [CntW-1:0]  motion_latch_q;
  logic             fused_prev_q;

  // sequencer and divider
  logic [SlotW-1:0]   slot_q;
  logic [DivCtrW-1:0] div_ctr_q;
  logic [TotW-1:0]    quo_q;
  logic [1:0]         rem_q;

  // result register
  logic             out_valid_q;
  logic             fused_q;
  logic             pres_out_q;
  logic             pres_flip_q;
  logic             fused_flip_q;
  logic [NearW-1:0] near_out_q;
  logic             center_ok_q;
  logic [MagW-1:0]  mean_q;
  logic [MotW-1:0]  mcount_out_q;
  logic [CntW-1:0]  latch_out_q;

  // --- per-slot compare and accumulate ---
  logic [IdxW-1:0]  slot_zone;
  logic             slot_hit;
  logic [TotW-1:0]  total_d;
  logic [HitW-1:0]  hits_d;
  logic             in_accept;
  logic             status_ok;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign status_ok = (zone_status_i == StatusValidA) || (zone_status_i == StatusValidB);

  assign slot_zone = center_map_q[IdxW*slot_q +: IdxW];
  assign slot_hit  = usable_q && (slot_zone == zone_idx_q) && (center_hits_q < HitsLim);
  assign total_d   = slot_hit ? center_total_q + TotW'(dist_q) : center_total_q;
  assign hits_d    = slot_hit ? center_hits_q + HitW'(1) : center_hits_q;

  // --- divider step ---
  logic [2:0] div_trial;
  logic       div_ge;
  logic [2:0] div_diff;

  assign div_trial = {rem_q, quo_q[TotW-1]};
  assign div_ge    = div_trial >= center_hits_q;
  assign div_diff  = div_trial - center_hits_q;

  // --- frame close-out ---
  logic            near_present;
  logic [CntW-1:0] streak_inc;
  logic            presence_d;
  logic            flipped_d;
  logic [CntW-1:0] streak_d;
  logic [CntW-1:0] latch_d;
  logic            fused_d;
  logic            out_free;

  assign near_present = near_tally_q >= min_near_q;
  assign streak_inc   = flip_streak_q + CntW'(1);

  always_comb begin
    presence_d = presence_q;
    flipped_d  = 1'b0;
    streak_d   = '0;
    if (near_present != presence_q) begin
      if (streak_inc >= debounce_q) begin
        presence_d = near_present;
        flipped_d  = 1'b1;
      end else begin
        streak_d = streak_inc;
      end
    end
    if (mcount_q >= motion_min_q) begin
      latch_d = latch_reload_q;
    end else if (motion_latch_q != '0) begin
      latch_d = motion_latch_q - CntW'(1);
    end else begin
      latch_d = '0;
    end
  end

  assign fused_d  = presence_d && (latch_d != '0);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      near_dist_q    <= 15'd1000;
      min_near_q     <= 7'd8;
      debounce_q     <= 8'd3;
      motion_min_q   <= 5'd1;
      latch_reload_q <= 8'd75;
      center_map_q   <= 24'd9582363;
      zone_idx_q     <= '0;
      dist_q         <= '0;
      usable_q       <= 1'b0;
      last_q         <= 1'b0;
      mcount_q       <= '0;
      near_tally_q   <= '0;
      center_total_q <= '0;
      center_hits_q  <= '0;
      presence_q     <= 1'b0;
      flip_streak_q  <= '0;
      motion_latch_q <= '0;
      fused_prev_q   <= 1'b0;
      slot_q         <= '0;
      div_ctr_q      <= '0;
      quo_q          <= '0;
      rem_q          <= '0;
      out_valid_q    <= 1'b0;
      fused_q        <= 1'b0;
      pres_out_q     <= 1'b0;
      pres_flip_q    <= 1'b0;
      fused_flip_q   <= 1'b0;
      near_out_q     <= '0;
      center_ok_q    <= 1'b0;
      mean_q         <= '0;
      mcount_out_q   <= '0;
      latch_out_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_NEAR_DIST:  near_dist_q    <= cfg_data_i[MagW-1:0];
          REG_MIN_NEAR:   min_near_q     <= cfg_data_i[NearW-1:0];
          REG_DEBOUNCE:   debounce_q     <= cfg_data_i[CntW-1:0];
          REG_MOTION_MIN: motion_min_q   <= cfg_data_i[MotW-1:0];
          REG_LATCH_RELD: latch_reload_q <= cfg_data_i[CntW-1:0];
          REG_CENTER_MAP: center_map_q   <= cfg_data_i[MapW-1:0];
          default: ;
        endcase
      end

      // the close-out cycle reloads the result register itself
      if (out_valid_q && !out_stall_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            zone_idx_q <= zone_index_i;
            dist_q     <= zone_distance_i[MagW-1:0];
            usable_q   <= status_ok && (zone_distance_i > 0) &&
                          ({1'b0, zone_index_i} < ZonesLim);
            last_q     <= last_zone_i;
            mcount_q   <= motion_count_i;
            slot_q     <= '0;
            state_q    <= S_SLOT;
          end
        end
        S_SLOT: begin
          // near test rides along with the first slot
          if (slot_q == '0 && usable_q && dist_q <= near_dist_q &&
              near_tally_q < ZonesLim) begin
            near_tally_q <= near_tally_q + NearW'(1);
          end
          center_total_q <= total_d;
          center_hits_q  <= hits_d;
          quo_q          <= total_d;
          rem_q          <= '0;
          div_ctr_q      <= '0;
          if (slot_q == LastSlot) begin
            if (!last_q) begin
              state_q <= S_IDLE;
            end else if (hits_d == '0) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_DIV;
            end
          end else begin
            slot_q <= slot_q + SlotW'(1);
          end
        end
        S_DIV: begin
          rem_q     <= div_ge ? div_diff[1:0] : div_trial[1:0];
          quo_q     <= {quo_q[TotW-2:0], div_ge};
          div_ctr_q <= div_ctr_q + DivCtrW'(1);
          if (div_ctr_q == DivLast) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            fused_q        <= fused_d;
            pres_out_q     <= presence_d;
            pres_flip_q    <= flipped_d;
            fused_flip_q   <= fused_d != fused_prev_q;
            near_out_q     <= near_tally_q;
            center_ok_q    <= center_hits_q != '0;
            mean_q         <= (center_hits_q != '0) ? quo_q[MagW-1:0] : '0;
            mcount_out_q   <= mcount_q;
            latch_out_q    <= latch_d;
            presence_q     <= presence_d;
            flip_streak_q  <= streak_d;
            motion_latch_q <= latch_d;
            fused_prev_q   <= fused_d;
            near_tally_q   <= '0;
            center_total_q <= '0;
            center_hits_q  <= '0;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o          = 1'b1;
  assign in_stall_o           = (state_q != S_IDLE);
  assign out_valid_o          = out_valid_q;
  assign fused_present_o      = fused_q;
  assign presence_confirmed_o = pres_out_q;
  assign presence_flipped_o   = pres_flip_q;
  assign fused_flipped_o      = fused_flip_q;
  assign near_zones_o         = near_out_q;
  assign center_ok_o          = center_ok_q;
  assign center_mean_mm_o     = mean_q;
  assign motion_count_echo_o  = mcount_out_q;
  assign latch_level_o        = latch_out_q;

endmodule

@@ verif/tof_zone_presence_fusion_tb.sv @@
// ----------------------------------------------------------------------------
// tof_zone_presence_fusion_tb
// Streams ranging zones into the presence fusion block and checks every frame
// result word against a frame-level predictor kept in step with the register
// settings. Covers directed edge frames, then randomised frames over several
// register settings, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tof_zone_presence_fusion_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tzpf_pkg::*;

  localparam int unsigned ZONES         = 64;
  localparam int unsigned CENTER_COUNT  = 4;
  localparam int unsigned IDLE_PCT      = 17;
  localparam int unsigned SETTLE_CYCLES = 40;    // zone walk plus divider and close-out
  localparam int unsigned DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic              fused;
    logic              present;
    logic              present_flip;
    logic              fused_flip;
    logic [NearW-1:0]  near_cnt;
    logic              centre_ok;
    logic [MagW-1:0]   centre_mean;
    logic [MotW-1:0]   motion;
    logic [CntW-1:0]   latch;
  } frame_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [CfgDatW-1:0]       cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [IdxW-1:0]          zone_index_i;
  logic signed [DistW-1:0]  zone_distance_i;
  logic [StatW-1:0]         zone_status_i;
  logic                     last_zone_i;
  logic [MotW-1:0]          motion_count_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     fused_present_o;
  logic                     presence_confirmed_o;
  logic                     presence_flipped_o;
  logic                     fused_flipped_o;
  logic [NearW-1:0]         near_zones_o;
  logic                     center_ok_o;
  logic [MagW-1:0]          center_mean_mm_o;
  logic [MotW-1:0]          motion_count_echo_o;
  logic [CntW-1:0]          latch_level_o;

  // register shadows, reset values
  int unsigned     cfg_near_mm      = 1000;
  int unsigned     cfg_min_near     = 8;
  int unsigned     cfg_debounce     = 3;
  int unsigned     cfg_motion_min   = 1;
  int unsigned     cfg_latch_reload = 75;
  logic [MapW-1:0] cfg_centre_map   = {6'd36, 6'd35, 6'd28, 6'd27};

  // frame state of the predictor
  int unsigned near_tally;
  int unsigned centre_sum;
  int unsigned centre_hits;
  bit          present_q;
  int unsigned flip_streak;
  int unsigned latch_q;
  bit          fused_last;

  frame_result_t expected_frames[$];
  int unsigned   mismatch_count;
  int unsigned   zones_accepted;
  int unsigned   frames_checked;
  int unsigned   settings_applied;
  bit            calm;             // no idling on either side

  tof_zone_presence_fusion #(
    .ZONES        (ZONES),
    .CENTER_COUNT (CENTER_COUNT)
  ) u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .zone_index_i         (zone_index_i),
    .zone_distance_i      (zone_distance_i),
    .zone_status_i        (zone_status_i),
    .last_zone_i          (last_zone_i),
    .motion_count_i       (motion_count_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .fused_present_o      (fused_present_o),
    .presence_confirmed_o (presence_confirmed_o),
    .presence_flipped_o   (presence_flipped_o),
    .fused_flipped_o      (fused_flipped_o),
    .near_zones_o         (near_zones_o),
    .center_ok_o          (center_ok_o),
    .center_mean_mm_o     (center_mean_mm_o),
    .motion_count_echo_o  (motion_count_echo_o),
    .latch_level_o        (latch_level_o)
  );

  always #1ns clk_i = ~clk_i;

  // Folds one accepted zone into the frame; closes the frame on the last zone.
  function automatic void fuse_zone(logic [IdxW-1:0] idx, logic signed [DistW-1:0] distance,
                                    logic [StatW-1:0] status, logic last,
                                    logic [MotW-1:0] mcount);
    frame_result_t res;
    int            mm;
    bit            raw_present;
    bit            flipped;
    bit            fused;
    mm = int'(distance);
    if (idx < ZONES && (status == StatusValidA || status == StatusValidB) && mm > 0) begin
      if (mm <= int'(cfg_near_mm) && near_tally < ZONES) begin
        near_tally++;
      end
      // duplicate slots each count, up to the per-frame hit limit
      for (int k = 0; k < CENTER_COUNT; k++) begin
        if (cfg_centre_map[IdxW*k +: IdxW] == idx && centre_hits < CENTER_COUNT) begin
          centre_sum += mm;
          centre_hits++;
        end
      end
    end
    if (!last) begin
      return;
    end
    raw_present = near_tally >= cfg_min_near;
    flipped     = 1'b0;
    if (raw_present != present_q) begin
      flip_streak++;
      if (flip_streak >= cfg_debounce) begin
        present_q   = raw_present;
        flip_streak = 0;
        flipped     = 1'b1;
      end
    end else begin
      flip_streak = 0;
    end
    if (mcount >= cfg_motion_min) begin
      latch_q = cfg_latch_reload;
    end else if (latch_q > 0) begin
      latch_q--;
    end
    fused = present_q && latch_q > 0;
    res.fused        = fused;
    res.present      = present_q;
    res.present_flip = flipped;
    res.fused_flip   = fused != fused_last;
    res.near_cnt     = NearW'(near_tally);
    res.centre_ok    = centre_hits > 0;
    res.centre_mean  = MagW'((centre_hits > 0) ? centre_sum / centre_hits : 0);
    res.motion       = mcount;
    res.latch        = CntW'(latch_q);
    expected_frames.push_back(res);
    fused_last  = fused;
    near_tally  = 0;
    centre_sum  = 0;
    centre_hits = 0;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : zone_predictor
    if (rst_ni && in_valid_i && !in_stall_o) begin
      zones_accepted++;
      fuse_zone(zone_index_i, zone_distance_i, zone_status_i, last_zone_i, motion_count_i);
    end
  end

  always @(posedge clk_i) begin : frame_checker
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      frames_checked++;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result word, expected none got near %0d mean %0d latch %0d",
                 $time, near_zones_o, center_mean_mm_o, latch_level_o);
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        check_field("fused_present", 32'(want.fused), 32'(fused_present_o));
        check_field("presence_confirmed", 32'(want.present), 32'(presence_confirmed_o));
        check_field("presence_flipped", 32'(want.present_flip), 32'(presence_flipped_o));
        check_field("fused_flipped", 32'(want.fused_flip), 32'(fused_flipped_o));
        check_field("near_zones", 32'(want.near_cnt), 32'(near_zones_o));
        check_field("center_ok", 32'(want.centre_ok), 32'(center_ok_o));
        check_field("center_mean_mm", 32'(want.centre_mean), 32'(center_mean_mm_o));
        check_field("motion_count_echo", 32'(want.motion), 32'(motion_count_echo_o));
        check_field("latch_level", 32'(want.latch), 32'(latch_level_o));
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Leaves valid high after acceptance; a drain, or a gap in a later call, lowers it.
  task automatic send_zone(logic [IdxW-1:0] idx, logic signed [DistW-1:0] distance,
                           logic [StatW-1:0] status, logic last, logic [MotW-1:0] mcount);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    zone_index_i    <= idx;
    zone_distance_i <= distance;
    zone_status_i   <= status;
    last_zone_i     <= last;
    motion_count_i  <= mcount;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (r)
      REG_NEAR_DIST:  cfg_near_mm      = 32'(data[MagW-1:0]);
      REG_MIN_NEAR:   cfg_min_near     = 32'(data[NearW-1:0]);
      REG_DEBOUNCE:   cfg_debounce     = 32'(data[CntW-1:0]);
      REG_MOTION_MIN: cfg_motion_min   = 32'(data[MotW-1:0]);
      REG_LATCH_RELD: cfg_latch_reload = 32'(data[CntW-1:0]);
      REG_CENTER_MAP: cfg_centre_map   = data[MapW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int unsigned near_mm, int unsigned min_near,
                                int unsigned debounce, int unsigned motion_min,
                                int unsigned latch_reload, logic [MapW-1:0] centre_map);
    wait_drained();
    write_reg(REG_NEAR_DIST, CfgDatW'(near_mm));
    write_reg(REG_MIN_NEAR, CfgDatW'(min_near));
    write_reg(REG_DEBOUNCE, CfgDatW'(debounce));
    write_reg(REG_MOTION_MIN, CfgDatW'(motion_min));
    write_reg(REG_LATCH_RELD, CfgDatW'(latch_reload));
    write_reg(REG_CENTER_MAP, centre_map);
    cfg_valid_i <= 1'b0;
    settings_applied++;
  endtask

  // Well-formed frames with random content; presence and absence come in runs
  // so the debounce streaks can complete. A tenth of the words are pure noise.
  task automatic run_frames(int unsigned n_zones);
    int unsigned             sent;
    int unsigned             len;
    int unsigned             near_max;
    bit                      present_mode;
    logic [IdxW-1:0]         idx;
    logic signed [DistW-1:0] distance;
    logic [StatW-1:0]        status;
    logic [MotW-1:0]         mcount;
    sent         = 0;
    present_mode = 1'b1;
    while (sent < n_zones) begin
      if ($urandom_range(0, 4) == 0) begin
        present_mode = !present_mode;
      end
      if ($urandom_range(0, 19) == 0) begin
        len = $urandom_range(65, 72);
      end else if (cfg_min_near > 16) begin
        len = cfg_min_near + $urandom_range(0, 4);
      end else begin
        len = $urandom_range(1, 20);
      end
      near_max = (cfg_near_mm == 0) ? 1 : cfg_near_mm;
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) < 4) begin
          idx = cfg_centre_map[IdxW*$urandom_range(0, CENTER_COUNT-1) +: IdxW];
        end else begin
          idx = IdxW'($urandom_range(0, ZONES-1));
        end
        if ($urandom_range(0, 9) < (present_mode ? 9 : 3)) begin
          status = $urandom_range(0, 1) ? StatusValidA : StatusValidB;
        end else begin
          status = StatW'($urandom_range(0, 255));
        end
        if (present_mode && $urandom_range(0, 9) < 8) begin
          distance = DistW'($urandom_range(1, near_max));
        end else begin
          distance = DistW'($urandom_range(1, 32767));
        end
        if ($urandom_range(0, 9) == 0) begin
          idx      = IdxW'($urandom_range(0, 63));
          distance = DistW'($urandom_range(0, 65535));
          status   = StatW'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 3) == 0) begin
          mcount = MotW'($urandom_range(cfg_motion_min, 16));
        end else begin
          mcount = MotW'($urandom_range(0, 16));
        end
        send_zone(idx, distance, status, i == len - 1, mcount);
        sent++;
      end
    end
  endtask

  // Reset settings: near boundary, status codes, sign and zero distance,
  // centre hit limit, motion count on a non-last zone, empty frame.
  task automatic test_default_frames();
    send_zone(6'd27, 16'sd1000, StatusValidA, 1'b0, 5'd16);
    send_zone(6'd28, 16'sd1001, StatusValidB, 1'b0, 5'd0);
    send_zone(6'd35, 16'sd32767, StatusValidA, 1'b0, 5'd0);
    send_zone(6'd36, 16'sh8000, StatusValidA, 1'b0, 5'd0);
    send_zone(6'd36, 16'sd0, StatusValidB, 1'b0, 5'd0);
    send_zone(6'd27, 16'sd1, 8'd4, 1'b0, 5'd0);
    send_zone(6'd0, 16'sd1, 8'd255, 1'b0, 5'd0);
    send_zone(6'd63, 16'sd1, StatusValidB, 1'b0, 5'd0);
    send_zone(6'd36, 16'sd500, StatusValidB, 1'b1, 5'd0);
    // fifth centre hit is dropped; repeated zone counts twice
    send_zone(6'd27, 16'sd10, StatusValidA, 1'b0, 5'd0);
    send_zone(6'd27, 16'sd20, StatusValidA, 1'b0, 5'd0);
    send_zone(6'd28, 16'sd30, StatusValidB, 1'b0, 5'd0);
    send_zone(6'd35, 16'sd40, StatusValidA, 1'b0, 5'd0);
    send_zone(6'd36, 16'sd50, StatusValidA, 1'b1, 5'd16);
    send_zone(6'd0, 16'sd0, 8'd0, 1'b1, 5'd1);
  endtask

  // Extreme register values: zero debounce, duplicate centre slots, no near
  // range, largest thresholds.
  task automatic test_boundary_settings();
    apply_settings(32767, 0, 0, 0, 255, {4{6'd10}});
    send_zone(6'd10, 16'sd32767, StatusValidB, 1'b0, 5'd3);
    send_zone(6'd10, 16'sd5, StatusValidA, 1'b1, 5'd0);
    send_zone(6'd10, 16'sd7, StatusValidA, 1'b1, 5'd0);
    apply_settings(0, 64, 1, 16, 0, 24'hFFFFFF);
    send_zone(6'd63, 16'sd100, StatusValidB, 1'b1, 5'd15);
    send_zone(6'd63, 16'sd1, StatusValidA, 1'b1, 5'd16);
    send_zone(6'd62, 16'sd100, StatusValidA, 1'b1, 5'd0);
  endtask

  task automatic test_mixed_traffic();
    apply_settings(1000, 8, 3, 1, 6, {6'd36, 6'd35, 6'd28, 6'd27});
    run_frames(200);
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    apply_settings(1500, 2, 1, 4, 2, MapW'($urandom_range(0, 24'hFFFFFF)));
    run_frames(200);
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_full_frames();
    apply_settings(32767, 64, 2, 16, 255, {6'd0, 6'd63, 6'd9, 6'd54});
    run_frames(250);
  endtask

  task automatic test_slow_debounce();
    apply_settings(300, 0, 255, 8, 1, {6'd5, 6'd5, 6'd17, 6'd40});
    run_frames(150);
  endtask

  task automatic test_all_zero_settings();
    apply_settings(0, 0, 0, 0, 0, 24'd0);
    run_frames(150);
  endtask

  task automatic test_random_settings();
    repeat (2) begin
      apply_settings($urandom_range(0, 32767), $urandom_range(0, 12), $urandom_range(1, 4),
                     $urandom_range(0, 16), $urandom_range(0, 20),
                     MapW'($urandom_range(0, 24'hFFFFFF)));
      run_frames(130);
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= REG_NEAR_DIST;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    zone_index_i    <= '0;
    zone_distance_i <= '0;
    zone_status_i   <= '0;
    last_zone_i     <= 1'b0;
    motion_count_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_frames();
    test_boundary_settings();
    test_mixed_traffic();
    test_back_to_back();
    test_full_frames();
    test_slow_debounce();
    test_all_zero_settings();
    test_random_settings();

    in_valid_i <= 1'b0;
    for (int unsigned c = 0; c < DRAIN_LIMIT && expected_frames.size() != 0; c++) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_frames.size() != 0) begin
      $display("%0t: %0d frame results never arrived", $time, expected_frames.size());
      mismatch_count += expected_frames.size();
    end
    $display("Streamed %0d zones, compared %0d frame results over %0d register settings",
             zones_accepted, frames_checked, settings_applied + 1);
    $display("including zero and full-scale thresholds, duplicate centre slots and long frames");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
